[design/assert_macros.svh]
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[design/adpnd_pkg.sv]
package adpnd_pkg;

  localparam logic        REQ_READ  = 1'b0;
  localparam logic        REQ_WRITE = 1'b1;

  localparam logic [15:0] PORT_CTRL   = 16'h00D6;
  localparam logic [15:0] PORT_SAMPLE = 16'h00D8;
  localparam logic [15:0] PORT_OUT    = 16'h00D9;

  localparam logic [9:0]  ACC_RESET     = 10'h100;
  localparam logic [9:0]  ACC_CLIP_HIGH = 10'h300;
  localparam logic [9:0]  ACC_CLIP_LOW  = 10'h200;

  localparam logic [7:0]  READ_IDLE  = 8'hFF;
  localparam logic [7:0]  READ_ZERO  = 8'h00;

  // Step magnitude by step index and the low three bits of the code.
  // Bit 3 of the code selects the sign.
  localparam logic [7:0] STEP_MAG [16][8] = '{
    '{8'd0, 8'd0,  8'd1,  8'd2,  8'd3,  8'd5,   8'd7,   8'd10},
    '{8'd0, 8'd1,  8'd2,  8'd3,  8'd4,  8'd6,   8'd8,   8'd13},
    '{8'd0, 8'd1,  8'd2,  8'd4,  8'd5,  8'd7,   8'd10,  8'd15},
    '{8'd0, 8'd1,  8'd3,  8'd4,  8'd6,  8'd9,   8'd13,  8'd19},
    '{8'd0, 8'd2,  8'd3,  8'd5,  8'd8,  8'd11,  8'd15,  8'd23},
    '{8'd0, 8'd2,  8'd4,  8'd7,  8'd10, 8'd14,  8'd19,  8'd29},
    '{8'd0, 8'd3,  8'd5,  8'd8,  8'd12, 8'd16,  8'd22,  8'd33},
    '{8'd1, 8'd4,  8'd7,  8'd10, 8'd15, 8'd20,  8'd29,  8'd43},
    '{8'd1, 8'd4,  8'd8,  8'd13, 8'd18, 8'd25,  8'd35,  8'd53},
    '{8'd1, 8'd6,  8'd10, 8'd16, 8'd22, 8'd31,  8'd43,  8'd64},
    '{8'd2, 8'd7,  8'd12, 8'd19, 8'd27, 8'd37,  8'd51,  8'd76},
    '{8'd2, 8'd9,  8'd16, 8'd24, 8'd34, 8'd46,  8'd64,  8'd96},
    '{8'd3, 8'd11, 8'd19, 8'd29, 8'd41, 8'd57,  8'd79,  8'd117},
    '{8'd4, 8'd13, 8'd24, 8'd36, 8'd50, 8'd69,  8'd96,  8'd143},
    '{8'd4, 8'd16, 8'd29, 8'd44, 8'd62, 8'd85,  8'd118, 8'd175},
    '{8'd6, 8'd20, 8'd36, 8'd54, 8'd76, 8'd104, 8'd144, 8'd214}
  };

  localparam logic signed [2:0] INDEX_MOVE [8] = '{
    -3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd2, 3'sd3
  };

  typedef struct packed {
    logic        req_type;
    logic [15:0] port_address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic       enabled;
    logic [9:0] accumulator;
    logic [3:0] step_index;
    logic       nibble_phase;
  } status_t;

endpackage

[design/adpnd_if.sv]
interface adpnd_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] port_address;
  logic [7:0]  write_data;

  modport source(output valid, req_type, port_address, write_data, input ready);
  modport sink(input valid, req_type, port_address, write_data, output ready);
endinterface

interface adpnd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source(output valid, read_data, input ready);
  modport sink(input valid, read_data, output ready);
endinterface

[design/adpcm_nibble_decoder_port.sv]
// An accepted beat is held in the input register, and its result is then
// registered in the result register, from which the response side takes it.
// Throughput: one bus access per cycle while results are taken; the input
// and result registers let a new beat enter while a finished result waits.
// Reset (rst, synchronous, active high) empties both registers, disables
// the decoder and returns the accumulator to 0x100, step index and phase to 0.
`include "assert_macros.svh"

module adpcm_nibble_decoder_port
  import adpnd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  adpnd_req_if.sink    req,
  adpnd_rsp_if.source  rsp
);

  req_t       s1_item;
  logic       s1_fire;
  logic [7:0] result;
  status_t    status;
  logic       write_fire;
  logic       decoder_clear;

  adpnd_port u_port (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .s1_item (s1_item),
    .s1_fire (s1_fire),
    .result  (result)
  );

  adpnd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (s1_fire),
    .item      (s1_item),
    .read_data (result),
    .status    (status)
  );

  assign write_fire    = s1_fire && (s1_item.req_type == REQ_WRITE);
  assign decoder_clear = (status.accumulator == ACC_RESET) && (status.step_index == 4'd0)
                         && !status.nibble_phase;

  `ASSERT_NEXT(a_write_reads_zero, clk, rst, write_fire, rsp.read_data == READ_ZERO)
  `ASSERT_NEXT(a_fire_gives_result, clk, rst, s1_fire, rsp.valid)
  `ASSERT_NOW(a_disabled_is_clear, clk, rst, !status.enabled, decoder_clear)
  `ASSERT_NOW(a_room_means_ready, clk, rst, !rsp.valid, req.ready)

endmodule

[design/adpnd_core.sv]
module adpnd_core
  import adpnd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  req_t       item,
  output logic [7:0] read_data,
  output status_t    status
);

  logic       enabled;
  logic [6:0] period_value;
  logic [9:0] accumulator;
  logic [3:0] step_index;
  logic       nibble_phase;

  logic       is_write;
  logic       hit_ctrl;
  logic       hit_sample;
  logic       hit_out;
  logic [3:0] nibble;
  logic [7:0] mag;
  logic [9:0] delta;
  logic [9:0] accumulator_next;
  logic [2:0] move;
  logic [5:0] index_sum;
  logic [3:0] step_index_next;

  assign is_write   = (item.req_type == REQ_WRITE);
  assign hit_ctrl   = (item.port_address == PORT_CTRL);
  assign hit_sample = (item.port_address == PORT_SAMPLE);
  assign hit_out    = (item.port_address == PORT_OUT);

  assign nibble = nibble_phase ? item.write_data[3:0] : item.write_data[7:4];
  assign mag    = STEP_MAG[step_index][nibble[2:0]];
  assign delta  = {2'b00, mag};
  assign accumulator_next = nibble[3] ? (accumulator - delta) : (accumulator + delta);

  assign move      = INDEX_MOVE[nibble[2:0]];
  assign index_sum = {2'b00, step_index} + {{3{move[2]}}, move};

  // Bit 5 flags a result below zero, bit 4 one above fifteen.
  always_comb begin
    priority if (index_sum[5]) begin
      step_index_next = 4'd0;
    end else if (index_sum[4]) begin
      step_index_next = 4'd15;
    end else begin
      step_index_next = index_sum[3:0];
    end
  end

  always_comb begin
    if (is_write) begin
      read_data = READ_ZERO;
    end else if (hit_ctrl) begin
      read_data = {enabled, period_value};
    end else if (hit_out) begin
      priority if (accumulator >= ACC_CLIP_HIGH) begin
        read_data = READ_ZERO;
      end else if (accumulator >= ACC_CLIP_LOW) begin
        read_data = READ_IDLE;
      end else begin
        read_data = accumulator[8:1];
      end
    end else begin
      read_data = READ_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b0;
      period_value <= 7'd0;
      accumulator  <= ACC_RESET;
      step_index   <= 4'd0;
      nibble_phase <= 1'b0;
    end else if (advance && is_write) begin
      if (hit_ctrl) begin
        enabled      <= item.write_data[7];
        period_value <= item.write_data[6:0];
        if (!item.write_data[7]) begin
          accumulator  <= ACC_RESET;
          step_index   <= 4'd0;
          nibble_phase <= 1'b0;
        end
      end else if (hit_sample && enabled) begin
        accumulator  <= accumulator_next;
        step_index   <= step_index_next;
        nibble_phase <= ~nibble_phase;
      end
    end
  end

  assign status = '{
    enabled:      enabled,
    accumulator:  accumulator,
    step_index:   step_index,
    nibble_phase: nibble_phase
  };

endmodule

[design/adpnd_port.sv]
module adpnd_port
  import adpnd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  adpnd_req_if.sink    req,
  adpnd_rsp_if.source  rsp,
  output req_t         s1_item,
  output logic         s1_fire,
  input  logic [7:0]   result
);

  logic s1_valid;
  logic out_valid;
  logic [7:0] out_data;

  // The held beat moves on whenever the result register is empty or draining.
  assign s1_fire   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_item <= '{
        req_type:     req.req_type,
        port_address: req.port_address,
        write_data:   req.write_data
      };
    end
    if (s1_fire) begin
      out_data <= result;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

endmodule
